// ----- rtl/eeg_pkt_pkg.sv -----
// Shared constants for the EEG headset packet parser.
// No dependencies; used by the parser top level and its port checker.
package eeg_pkt_pkg;

	localparam int BYTE_W    = 8;
	localparam int RAW_W     = 16;
	localparam int NUM_BANDS = 8;
	localparam int BANDS_W   = NUM_BANDS * BYTE_W;

	// framing
	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;
	localparam logic [BYTE_W-1:0] MAX_PLEN  = 8'd170;

	// row codes and lengths
	localparam logic [BYTE_W-1:0] CODE_QUALITY    = 8'h02;
	localparam logic [BYTE_W-1:0] CODE_ATTENTION  = 8'h04;
	localparam logic [BYTE_W-1:0] CODE_MEDITATION = 8'h05;
	localparam logic [BYTE_W-1:0] CODE_BLINK      = 8'h16;
	localparam logic [BYTE_W-1:0] CODE_RAW        = 8'h80;
	localparam logic [BYTE_W-1:0] CODE_BANDS      = 8'h83;
	localparam logic [BYTE_W-1:0] RAW_LEN         = 8'h02;
	localparam logic [BYTE_W-1:0] BANDS_LEN       = 8'h18;

endpackage

// ----- rtl/eeg_headset_packet_parser.sv -----
// Top level of the EEG headset packet parser: byte-serial framing, row walk, result word.
// Depends on eeg_pkt_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in      | sink      | in_valid / in_stall | data_byte
//  out     | source    | out_valid/out_stall | checksum_ok, signal_quality,
//          |           |                     | attention_level, meditation_level,
//          |           |                     | blink_strength, raw_wave, band_powers
//
// One byte per cycle sustained while in_stall is low: a byte waits in the input register, and the
// parser state updates as it leaves; a checksum byte loads the result register.
// in_stall rises only while a checksum byte waits and the result register is full and stalled.
// arst_n clears the framing state, the latched values and both valid flags.
module eeg_headset_packet_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [eeg_pkt_pkg::BYTE_W-1:0]    data_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              checksum_ok,
	output logic [eeg_pkt_pkg::BYTE_W-1:0]    signal_quality,
	output logic [eeg_pkt_pkg::BYTE_W-1:0]    attention_level,
	output logic [eeg_pkt_pkg::BYTE_W-1:0]    meditation_level,
	output logic [eeg_pkt_pkg::BYTE_W-1:0]    blink_strength,
	output logic signed [eeg_pkt_pkg::RAW_W-1:0] raw_wave,
	output logic [eeg_pkt_pkg::BANDS_W-1:0]   band_powers
);
	import eeg_pkt_pkg::*;

	typedef enum logic [2:0] {
		PH_SYNC1 = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_LEN   = 3'd2,
		PH_CODE  = 3'd3,
		PH_VLEN  = 3'd4,
		PH_VALUE = 3'd5,
		PH_CHECK = 3'd6
	} phase_t;

	typedef logic [NUM_BANDS-1:0][BYTE_W-1:0] bands_t;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// parser state
	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] remain_q, remain_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [BYTE_W-1:0] code_q, code_d;
	logic [BYTE_W-1:0] len_q, len_d;
	logic [BYTE_W-1:0] pos_q, pos_d;
	logic [BYTE_W-1:0] raw_hi_q, raw_hi_d;
	logic [BYTE_W-1:0] quality_q, quality_d;
	logic [BYTE_W-1:0] attention_q, attention_d;
	logic [BYTE_W-1:0] meditation_q, meditation_d;
	logic [BYTE_W-1:0] blink_q, blink_d;
	logic [RAW_W-1:0]  raw_q, raw_d;
	bands_t            bands_q, bands_d;

	logic              fire_s1;
	logic              in_accept;
	logic              emit;
	logic [BYTE_W-1:0] pos_inc;
	logic [BYTE_W-1:0] remain_dec;

	// byte in the input register moves on unless it would overwrite a stalled result
	assign fire_s1   = valid_s1 && !(phase_q == PH_CHECK && out_valid && out_stall);
	assign in_stall  = valid_s1 && !fire_s1;
	assign in_accept = in_valid && !in_stall;
	assign emit      = fire_s1 && (phase_q == PH_CHECK);

	assign pos_inc    = pos_q + BYTE_W'(1);
	assign remain_dec = remain_q - BYTE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= data_byte;
		end
	end

	// next-state logic for one byte
	always_comb begin
		phase_d      = phase_q;
		remain_d     = remain_q;
		sum_d        = sum_q;
		code_d       = code_q;
		len_d        = len_q;
		pos_d        = pos_q;
		raw_hi_d     = raw_hi_q;
		quality_d    = quality_q;
		attention_d  = attention_q;
		meditation_d = meditation_q;
		blink_d      = blink_q;
		raw_d        = raw_q;
		bands_d      = bands_q;
		unique case (phase_q)
			PH_SYNC2: begin
				phase_d = (byte_s1 == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
			end
			PH_LEN: begin
				if (byte_s1 == SYNC_BYTE) begin
					phase_d = PH_LEN;
				end else if (byte_s1 > MAX_PLEN) begin
					phase_d = PH_SYNC1;
				end else begin
					remain_d = byte_s1;
					sum_d    = '0;
					code_d   = '0;
					len_d    = '0;
					pos_d    = '0;
					phase_d  = (byte_s1 == '0) ? PH_CHECK : PH_CODE;
				end
			end
			PH_CODE, PH_VLEN, PH_VALUE: begin
				sum_d = sum_q + byte_s1;
				if (phase_q == PH_CODE) begin
					code_d = byte_s1;
					pos_d  = '0;
					if (byte_s1 >= CODE_RAW) begin
						phase_d = PH_VLEN;
					end else begin
						len_d   = BYTE_W'(1);
						phase_d = PH_VALUE;
					end
				end else if (phase_q == PH_VLEN) begin
					len_d   = byte_s1;
					pos_d   = '0;
					phase_d = (byte_s1 == '0) ? PH_CODE : PH_VALUE;
				end else begin
					// value byte: latch when the row is one we track
					if (len_q == BYTE_W'(1) && pos_q == '0) begin
						if (code_q == CODE_QUALITY)             quality_d    = byte_s1;
						else if (code_q == CODE_ATTENTION)      attention_d  = byte_s1;
						else if (code_q == CODE_MEDITATION)     meditation_d = byte_s1;
						else if (code_q == CODE_BLINK)          blink_d      = byte_s1;
					end else if (code_q == CODE_RAW && len_q == RAW_LEN) begin
						if (pos_q == '0) begin
							raw_hi_d = byte_s1;
						end else if (pos_q == BYTE_W'(1)) begin
							raw_d = {raw_hi_q, byte_s1};
						end
					end else if (code_q == CODE_BANDS && len_q == BANDS_LEN) begin
						// middle byte of each triple
						for (int k = 0; k < NUM_BANDS; k++) begin
							if (pos_q == BYTE_W'(3 * k + 1)) begin
								bands_d[k] = byte_s1;
							end
						end
					end
					pos_d = pos_inc;
					if (pos_inc >= len_q) begin
						phase_d = PH_CODE;
					end
				end
				remain_d = remain_dec;
				if (remain_dec == '0) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				phase_d = PH_SYNC1;
			end
			default: begin
				phase_d = (byte_s1 == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
			end
		endcase
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_SYNC1;
			remain_q         <= '0;
			sum_q            <= '0;
			code_q           <= '0;
			len_q            <= '0;
			pos_q            <= '0;
			raw_hi_q         <= '0;
			quality_q        <= '0;
			attention_q      <= '0;
			meditation_q     <= '0;
			blink_q          <= '0;
			raw_q            <= '0;
			bands_q          <= '0;
			out_valid        <= 1'b0;
			checksum_ok      <= 1'b0;
			signal_quality   <= '0;
			attention_level  <= '0;
			meditation_level <= '0;
			blink_strength   <= '0;
			raw_wave         <= '0;
			band_powers      <= '0;
		end else begin
			if (fire_s1) begin
				phase_q      <= phase_d;
				remain_q     <= remain_d;
				sum_q        <= sum_d;
				code_q       <= code_d;
				len_q        <= len_d;
				pos_q        <= pos_d;
				raw_hi_q     <= raw_hi_d;
				quality_q    <= quality_d;
				attention_q  <= attention_d;
				meditation_q <= meditation_d;
				blink_q      <= blink_d;
				raw_q        <= raw_d;
				bands_q      <= bands_d;
			end
			if (emit) begin
				out_valid        <= 1'b1;
				checksum_ok      <= (~sum_q == byte_s1);
				signal_quality   <= quality_q;
				attention_level  <= attention_q;
				meditation_level <= meditation_q;
				blink_strength   <= blink_q;
				raw_wave         <= raw_q;
				band_powers      <= bands_q;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/eeg_pkt_checker.sv -----
// Port-level checker for the EEG headset packet parser, bound to its top level.
// Depends on eeg_pkt_pkg and eeg_headset_packet_parser.
module eeg_pkt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              checksum_ok,
	input logic [eeg_pkt_pkg::BYTE_W-1:0]    signal_quality,
	input logic [eeg_pkt_pkg::RAW_W-1:0]     raw_wave,
	input logic [eeg_pkt_pkg::BANDS_W-1:0]   band_powers
);
	import eeg_pkt_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(checksum_ok)
			&& $stable(signal_quality) && $stable(raw_wave) && $stable(band_powers))
		else $error("result word changed while stalled");

	// input backpressure only comes from a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// a stalled input word stays offered
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("input word withdrawn while stalled");

	// the input is never stalled while the result register is empty
	a_idle_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

endmodule

bind eeg_headset_packet_parser eeg_pkt_checker u_eeg_pkt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.checksum_ok    (checksum_ok),
	.signal_quality (signal_quality),
	.raw_wave       (raw_wave),
	.band_powers    (band_powers)
);

// ----- bench/tb_top.sv -----
// Self-checking bench for eeg_headset_packet_parser: framed byte streams in, readings out.
// Depends on eeg_pkt_pkg and the parser top level; needs no files or arguments.
module tb_top;
	import eeg_pkt_pkg::*;

	localparam int STREAM_TARGET = 1300;
	localparam int CYCLE_LIMIT   = 100000;
	localparam int DRAIN_CYCLES  = 10;

	typedef enum logic [2:0] {
		HUNT_SYNC1, HUNT_SYNC2, READ_LEN, ROW_CODE, ROW_VLEN, ROW_VALUE, READ_CHECK
	} parse_phase_e;

	typedef struct packed {
		logic                sum_ok;
		logic [BYTE_W-1:0]   quality;
		logic [BYTE_W-1:0]   attention;
		logic [BYTE_W-1:0]   meditation;
		logic [BYTE_W-1:0]   blink;
		logic [RAW_W-1:0]    raw;
		logic [BANDS_W-1:0]  bands;
	} reading_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [BYTE_W-1:0]        data_byte = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     checksum_ok;
	logic [BYTE_W-1:0]        signal_quality;
	logic [BYTE_W-1:0]        attention_level;
	logic [BYTE_W-1:0]        meditation_level;
	logic [BYTE_W-1:0]        blink_strength;
	logic signed [RAW_W-1:0]  raw_wave;
	logic [BANDS_W-1:0]       band_powers;

	// byte stream waiting to be sent, and readings the parser still owes
	logic [BYTE_W-1:0] stream_bytes[$];
	reading_t          expected_readings[$];

	int  stream_total;
	int  bytes_accepted;
	int  readings_checked;
	int  bad_sum_readings;
	int  error_count;
	int  cycle_count;
	bit  byte_taken;

	// tracked parser state
	parse_phase_e      phase_q = HUNT_SYNC1;
	logic [7:0]        left_q = '0;
	logic [7:0]        sum_q = '0;
	logic [7:0]        code_q = '0;
	logic [7:0]        len_q = '0;
	logic [7:0]        pos_q = '0;
	logic [7:0]        raw_high_q = '0;
	reading_t          held_q = '0;

	eeg_headset_packet_parser i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_byte        (data_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.checksum_ok      (checksum_ok),
		.signal_quality   (signal_quality),
		.attention_level  (attention_level),
		.meditation_level (meditation_level),
		.blink_strength   (blink_strength),
		.raw_wave         (raw_wave),
		.band_powers      (band_powers)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got,
			want);
		error_count++;
	endtask

	// idle rates per third of the stream: receiver-heavy, sender-heavy, then none
	function automatic int idle_pct(input bit sender);
		if (bytes_accepted < stream_total / 3)
			return sender ? 38 : 48;
		else if (bytes_accepted < 2 * stream_total / 3)
			return sender ? 48 : 38;
		else
			return 0;
	endfunction

	// Advance the tracked parser by one accepted word; a checksum byte yields a reading.
	task automatic track_byte(input logic [7:0] b);
		reading_t r;
		case (phase_q)
			HUNT_SYNC2: phase_q = (b == SYNC_BYTE) ? READ_LEN : HUNT_SYNC1;
			READ_LEN: begin
				// a further sync byte keeps us waiting for the length
				if (b != SYNC_BYTE) begin
					if (b > MAX_PLEN) begin
						phase_q = HUNT_SYNC1;
					end else begin
						left_q = b;
						sum_q = '0;
						code_q = '0;
						len_q = '0;
						pos_q = '0;
						phase_q = (b == 8'd0) ? READ_CHECK : ROW_CODE;
					end
				end
			end
			ROW_CODE, ROW_VLEN, ROW_VALUE: begin
				sum_q = sum_q + b;
				case (phase_q)
					ROW_CODE: begin
						code_q = b;
						pos_q = '0;
						if (b >= CODE_RAW) begin
							phase_q = ROW_VLEN;
						end else begin
							len_q = 8'd1;
							phase_q = ROW_VALUE;
						end
					end
					ROW_VLEN: begin
						len_q = b;
						pos_q = '0;
						phase_q = (b == 8'd0) ? ROW_CODE : ROW_VALUE;
					end
					default: begin
						if (len_q == 8'd1 && pos_q == 8'd0) begin
							case (code_q)
								CODE_QUALITY:    held_q.quality = b;
								CODE_ATTENTION:  held_q.attention = b;
								CODE_MEDITATION: held_q.meditation = b;
								CODE_BLINK:      held_q.blink = b;
								default: ;
							endcase
						end else if (code_q == CODE_RAW && len_q == RAW_LEN) begin
							if (pos_q == 8'd0)
								raw_high_q = b;
							else if (pos_q == 8'd1)
								held_q.raw = {raw_high_q, b};
						end else if (code_q == CODE_BANDS && len_q == BANDS_LEN) begin
							// middle byte of each triple
							if (pos_q < BANDS_LEN && pos_q % 3 == 1)
								held_q.bands[int'(pos_q / 3) * 8 +: 8] = b;
						end
						pos_q = pos_q + 8'd1;
						if (pos_q >= len_q)
							phase_q = ROW_CODE;
					end
				endcase
				// the byte after the payload is always the checksum
				left_q = left_q - 8'd1;
				if (left_q == 8'd0)
					phase_q = READ_CHECK;
			end
			READ_CHECK: begin
				r = held_q;
				r.sum_ok = (8'(~sum_q) == b);
				expected_readings.push_back(r);
				phase_q = HUNT_SYNC1;
			end
			default: phase_q = (b == SYNC_BYTE) ? HUNT_SYNC2 : HUNT_SYNC1;
		endcase
	endtask

	// Frame a payload: two syncs, optional extra sync, length, payload, checksum.
	task automatic queue_packet(input logic [7:0] body[$], input bit good_sum,
			input bit extra_sync);
		logic [7:0] sum;
		sum = '0;
		stream_bytes.push_back(SYNC_BYTE);
		stream_bytes.push_back(SYNC_BYTE);
		if (extra_sync)
			stream_bytes.push_back(SYNC_BYTE);
		stream_bytes.push_back(8'(body.size()));
		foreach (body[i]) begin
			stream_bytes.push_back(body[i]);
			sum = sum + body[i];
		end
		if (good_sum)
			stream_bytes.push_back(~sum);
		else
			stream_bytes.push_back((~sum) ^ 8'($urandom_range(1, 255)));
	endtask

	// Driver: a new word only once the current one is taken or none is up.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || byte_taken) begin
				if (stream_bytes.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
					data_byte <= stream_bytes.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < idle_pct(1'b0));
			byte_taken = 1'b0;
		end
	end

	// Monitor: track accepted words, check accepted readings in order.
	always @(posedge clk) begin
		reading_t want;
		cycle_count++;
		if (arst_n && in_valid && !in_stall) begin
			byte_taken = 1'b1;
			track_byte(data_byte);
			bytes_accepted++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				flag_mismatch("reading with none pending, checksum_ok", checksum_ok, 0);
			end else begin
				want = expected_readings.pop_front();
				readings_checked++;
				if (!want.sum_ok)
					bad_sum_readings++;
				if (checksum_ok !== want.sum_ok)
					flag_mismatch("checksum_ok", checksum_ok, want.sum_ok);
				if (signal_quality !== want.quality)
					flag_mismatch("signal_quality", signal_quality, want.quality);
				if (attention_level !== want.attention)
					flag_mismatch("attention_level", attention_level, want.attention);
				if (meditation_level !== want.meditation)
					flag_mismatch("meditation_level", meditation_level, want.meditation);
				if (blink_strength !== want.blink)
					flag_mismatch("blink_strength", blink_strength, want.blink);
				if (raw_wave !== want.raw)
					flag_mismatch("raw_wave", {48'd0, raw_wave}, {48'd0, want.raw});
				if (band_powers !== want.bands)
					flag_mismatch("band_powers", band_powers, want.bands);
			end
		end
	end

	initial begin
		logic [7:0] body[$];
		logic [7:0] code;
		int kind;
		int nrows;
		int target_len;
		int rk;
		int n;
		int shape;

		// directed: missing second sync, sync as length then empty packet,
		// oversize length, one-byte codes incl. extended prefix, raw at minimum,
		// wrong bands length, and a row cut off by the payload end
		stream_bytes = '{SYNC_BYTE, 8'h12,
			SYNC_BYTE, SYNC_BYTE, SYNC_BYTE, 8'h00, 8'hFF,
			SYNC_BYTE, SYNC_BYTE, 8'hAB};
		body = '{CODE_QUALITY, 8'hC8, CODE_ATTENTION, 8'h64, CODE_MEDITATION, 8'h00,
			8'h55, 8'h7F, 8'h90, 8'h00};
		queue_packet(body, 1'b1, 1'b0);
		body = '{CODE_RAW, RAW_LEN, 8'h80, 8'h00, CODE_BANDS, 8'h01, 8'h11, CODE_BLINK};
		queue_packet(body, 1'b0, 1'b1);

		// random: mostly well-formed packets, some broken framing and line noise
		while (stream_bytes.size() < STREAM_TARGET) begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				body.delete();
				target_len = ($urandom_range(99) < 3) ? $urandom_range(100, 170) : 0;
				nrows = $urandom_range(0, 5);
				for (int i = 0; i < nrows || body.size() < target_len; i++) begin
					rk = $urandom_range(9);
					if (rk <= 4) begin
						case (rk)
							0: code = CODE_QUALITY;
							1: code = CODE_ATTENTION;
							2: code = CODE_MEDITATION;
							3: code = CODE_BLINK;
							default: code = 8'($urandom_range(0, 127));
						endcase
						body.push_back(code);
						body.push_back(8'($urandom));
					end else if (rk <= 6) begin
						body.push_back(CODE_RAW);
						body.push_back(RAW_LEN);
						repeat (2) body.push_back(8'($urandom));
					end else if (rk == 7) begin
						body.push_back(CODE_BANDS);
						body.push_back(BANDS_LEN);
						repeat (24) body.push_back(8'($urandom));
					end else begin
						// unknown multi-byte row, or raw/bands with an odd length
						code = 8'($urandom_range(128, 255));
						if (rk == 9)
							code = $urandom_range(1) ? CODE_RAW : CODE_BANDS;
						n = $urandom_range(0, 5);
						body.push_back(code);
						body.push_back(8'(n));
						repeat (n) body.push_back(8'($urandom));
					end
				end
				// sometimes cut a row short or pad the tail
				shape = $urandom_range(99);
				if (shape < 10 && body.size() > 0) begin
					n = $urandom_range(0, body.size() - 1);
					while (body.size() > n) void'(body.pop_back());
				end else if (shape < 15) begin
					repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
				end
				while (body.size() > MAX_PLEN) void'(body.pop_back());
				queue_packet(body, $urandom_range(99) < 85, $urandom_range(99) < 10);
			end else if (kind < 90) begin
				stream_bytes.push_back(SYNC_BYTE);
				if ($urandom_range(1)) begin
					stream_bytes.push_back(8'($urandom_range(0, 8'hA9)));
				end else begin
					stream_bytes.push_back(SYNC_BYTE);
					stream_bytes.push_back(8'($urandom_range(171, 255)));
				end
			end else begin
				repeat ($urandom_range(1, 4)) stream_bytes.push_back(8'($urandom));
			end
		end
		stream_total = stream_bytes.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!(bytes_accepted == stream_total && expected_readings.size() == 0)
				&& cycle_count < CYCLE_LIMIT)
			@(negedge clk);

		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles: %0d of %0d bytes taken, %0d readings pending",
				cycle_count, bytes_accepted, stream_total, expected_readings.size());
			$display("Testbench completed WITH ERRORS");
		end else begin
			repeat (DRAIN_CYCLES) @(negedge clk);
			$display("Parsed %0d stream bytes; checked %0d readings, %0d with a bad checksum.",
				bytes_accepted, readings_checked, bad_sum_readings);
			if (error_count == 0)
				$display("Testbench completed without errors");
			else
				$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
